/* rtl/u8dw_pkg.sv */
// shared types, constants and column width tables of the display width meter
package u8dw_pkg;

    typedef logic [20:0] cp_t;

    localparam int COUNT_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam logic [15:0] MAX_WIDTH_RST = 16'd80;
    localparam cp_t REPL_CP = 21'h00FFFD;

    localparam int ZERO_N = 8;
    localparam int WIDE_N = 22;

    localparam cp_t ZERO_LO [ZERO_N] = '{
        21'h00300, 21'h00483, 21'h00591, 21'h0200B,
        21'h02028, 21'h0FE00, 21'h0FE20, 21'h01AB0};
    localparam cp_t ZERO_HI [ZERO_N] = '{
        21'h0036F, 21'h00489, 21'h005BD, 21'h0200F,
        21'h0202E, 21'h0FE0F, 21'h0FE2F, 21'h01AFF};

    localparam cp_t WIDE_LO [WIDE_N] = '{
        21'h01100, 21'h02E80, 21'h03041, 21'h03400, 21'h04E00, 21'h0A000,
        21'h0AC00, 21'h0F900, 21'h0FE10, 21'h0FE30, 21'h0FF00, 21'h0FFE0,
        21'h1F300, 21'h1F680, 21'h1F7E0, 21'h1F900, 21'h1FA70, 21'h1F004,
        21'h1F0CF, 21'h20000, 21'h30000, 21'h16FE0};
    localparam cp_t WIDE_HI [WIDE_N] = '{
        21'h0115F, 21'h0303E, 21'h033FF, 21'h04DBF, 21'h09FFF, 21'h0A4CF,
        21'h0D7A3, 21'h0FAFF, 21'h0FE19, 21'h0FE6F, 21'h0FF60, 21'h0FFE6,
        21'h1F64F, 21'h1F6FF, 21'h1F7FF, 21'h1F9FF, 21'h1FAFF, 21'h1F004,
        21'h1F0CF, 21'h2FFFD, 21'h3FFFD, 21'h16FFF};

    // display columns of one code point
    function automatic logic [1:0] cols_of(input cp_t cp);
        logic zero_hit;
        logic wide_hit;
        zero_hit = 1'b0;
        wide_hit = 1'b0;
        for (int i = 0; i < ZERO_N; i++)
        begin
            if (cp >= ZERO_LO[i] && cp <= ZERO_HI[i])
            begin
                zero_hit = 1'b1;
            end
        end
        for (int i = 0; i < WIDE_N; i++)
        begin
            if (cp >= WIDE_LO[i] && cp <= WIDE_HI[i])
            begin
                wide_hit = 1'b1;
            end
        end
        if (cp == '0)
        begin
            return 2'd0;
        end
        else if (cp < 21'h00300)
        begin
            return 2'd1;
        end
        else if (zero_hit)
        begin
            return 2'd0;
        end
        else if (wide_hit)
        begin
            return 2'd2;
        end
        return 2'd1;
    endfunction

    localparam logic [1:0] REPL_COLS = cols_of(REPL_CP);

    // one queued command: some replacements, then an optional tail code point
    typedef struct packed {
        logic [1:0] rep_cnt;
        logic       tail_vld;
        cp_t        tail_cp;
        logic [2:0] tail_cnt;
        logic       tail_rep;
        logic [1:0] tail_w;
        logic       last;
    } cmd_t;

    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_push_t;

    typedef struct packed {
        logic vld;
        cmd_t cmd;
    } q_head_t;

endpackage

/* rtl/u8dw_ifs.sv */
// handshake channels of the display width meter

interface u8dw_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;

    modport source (output valid, output text_byte, output last_byte, input ready);
    modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface u8dw_res_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [2:0]  byte_count;
    logic [1:0]  col_width;
    logic        replaced;
    logic [15:0] total_width;
    logic [15:0] prefix_width;
    logic        fits;
    logic        last_of_run;
    logic        end_of_text;

    modport source (
        output valid, output code_point, output byte_count, output col_width,
        output replaced, output total_width, output prefix_width, output fits,
        output last_of_run, output end_of_text, input ready);
    modport sink (
        input valid, input code_point, input byte_count, input col_width,
        input replaced, input total_width, input prefix_width, input fits,
        input last_of_run, input end_of_text, output ready);
endinterface

interface u8dw_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] max_width;

    modport source (output valid, output max_width, input ready);
    modport sink (input valid, input max_width, output ready);
endinterface

/* rtl/u8dw_front.sv */
// front end: utf-8 sequence decoder that queues a command for each byte that gives a beat
module u8dw_front (
    input  logic                clk,
    input  logic                rst_n,
    u8dw_byte_if.sink           text_in,
    input  logic                q_full,
    output u8dw_pkg::q_push_t   q_push
);

    logic [1:0]      need_reg, need_next;
    logic [1:0]      held_reg, held_next;
    u8dw_pkg::cp_t   part_reg, part_next;

    logic            accept;
    logic [7:0]      b;
    logic            cont;
    logic            fresh;
    logic [1:0]      held_inc;
    u8dw_pkg::cp_t   cpart;
    u8dw_pkg::cmd_t  cmd;

    assign text_in.ready = !q_full;
    assign accept = text_in.valid && !q_full;
    assign b = text_in.text_byte;
    assign cont = (b[7:6] == 2'b10);
    assign held_inc = held_reg + 2'd1;
    assign cpart = {part_reg[14:0], b[5:0]};

    always_comb
    begin
        need_next = need_reg;
        held_next = held_reg;
        part_next = part_reg;
        cmd = '0;
        cmd.last = text_in.last_byte;
        fresh = 1'b1;

        if (need_reg != 2'd0)
        begin
            if (cont)
            begin
                fresh = 1'b0;
                if (need_reg == 2'd1)
                begin
                    cmd.tail_vld = 1'b1;
                    cmd.tail_cp = cpart;
                    cmd.tail_cnt = 3'(held_inc) + 3'd1;
                    need_next = 2'd0;
                    held_next = 2'd0;
                    part_next = '0;
                end
                else if (text_in.last_byte)
                begin
                    cmd.rep_cnt = held_inc;
                    cmd.tail_vld = 1'b1;
                    cmd.tail_cp = u8dw_pkg::REPL_CP;
                    cmd.tail_cnt = 3'd1;
                    cmd.tail_rep = 1'b1;
                end
                else
                begin
                    need_next = need_reg - 2'd1;
                    held_next = held_inc;
                    part_next = cpart;
                end
            end
            else
            begin
                // bad continuation: flush lead and held bytes
                cmd.rep_cnt = held_inc;
                need_next = 2'd0;
                held_next = 2'd0;
                part_next = '0;
            end
        end

        if (fresh)
        begin
            unique casez (b)
                8'b0???????:
                begin
                    cmd.tail_vld = 1'b1;
                    cmd.tail_cp = u8dw_pkg::cp_t'(b);
                    cmd.tail_cnt = 3'd1;
                end
                8'b110?????, 8'b1110????, 8'b11110???:
                begin
                    if (text_in.last_byte)
                    begin
                        cmd.tail_vld = 1'b1;
                        cmd.tail_cp = u8dw_pkg::REPL_CP;
                        cmd.tail_cnt = 3'd1;
                        cmd.tail_rep = 1'b1;
                    end
                    else if (b[5] == 1'b0)
                    begin
                        need_next = 2'd1;
                        held_next = 2'd0;
                        part_next = u8dw_pkg::cp_t'(b[4:0]);
                    end
                    else if (b[4] == 1'b0)
                    begin
                        need_next = 2'd2;
                        held_next = 2'd0;
                        part_next = u8dw_pkg::cp_t'(b[3:0]);
                    end
                    else
                    begin
                        need_next = 2'd3;
                        held_next = 2'd0;
                        part_next = u8dw_pkg::cp_t'(b[2:0]);
                    end
                end
                default:
                begin
                    cmd.tail_vld = 1'b1;
                    cmd.tail_cp = u8dw_pkg::REPL_CP;
                    cmd.tail_cnt = 3'd1;
                    cmd.tail_rep = 1'b1;
                end
            endcase
        end

        cmd.tail_w = u8dw_pkg::cols_of(cmd.tail_cp);

        if (text_in.last_byte)
        begin
            need_next = 2'd0;
            held_next = 2'd0;
            part_next = '0;
        end
    end

    assign q_push.push = accept && (cmd.rep_cnt != 2'd0 || cmd.tail_vld);
    assign q_push.cmd = cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_reg <= 2'd0;
            held_reg <= 2'd0;
            part_reg <= '0;
        end
        else if (accept)
        begin
            need_reg <= need_next;
            held_reg <= held_next;
            part_reg <= part_next;
        end
    end

endmodule

/* rtl/u8dw_queue.sv */
// command queue between the decoder and the result stage
module u8dw_queue #(
    parameter int QUEUE_DEPTH = u8dw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  u8dw_pkg::q_push_t  q_push,
    output logic               q_full,
    output u8dw_pkg::q_head_t  q_head,
    input  logic               q_pop
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    u8dw_pkg::cmd_t  slot_reg [QUEUE_DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign q_full = (cnt_reg == FULL_CNT);
    assign do_push = q_push.push && !q_full;
    assign do_pop = q_pop && (cnt_reg != '0);
    assign q_head.vld = (cnt_reg != '0);
    assign q_head.cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= q_push.cmd;
        end
    end

endmodule

/* rtl/u8dw_back.sv */
// result stage: expands commands into beats and keeps the column counters
module u8dw_back #(
    parameter int COUNT_BITS = u8dw_pkg::COUNT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  u8dw_pkg::q_head_t  q_head,
    output logic               q_pop,
    input  logic [15:0]        max_width,
    u8dw_res_if.source         result_out
);

    localparam int SW = COUNT_BITS + 1;
    localparam int XW = (SW > 16) ? SW : 16;

    logic [1:0]            idx_reg, idx_next;
    logic [COUNT_BITS-1:0] total_reg, total_next;
    logic [COUNT_BITS-1:0] prefix_reg, prefix_next;
    logic                  open_reg, open_next;

    logic                  out_vld_reg;
    u8dw_pkg::cp_t         cp_reg;
    logic [2:0]            cnt_reg;
    logic [1:0]            w_reg;
    logic                  rep_reg;
    logic [15:0]           tot_out_reg;
    logic [15:0]           pre_out_reg;
    logic                  fit_reg;
    logic                  run_end_reg;
    logic                  text_end_reg;

    u8dw_pkg::cmd_t        cmd;
    logic                  fire;
    logic                  is_rep;
    logic                  is_last;
    logic [2:0]            n_res;
    u8dw_pkg::cp_t         cur_cp;
    logic [2:0]            cur_cnt;
    logic [1:0]            cur_w;
    logic                  cur_rep;
    logic [SW-1:0]         tot_sum;
    logic [SW-1:0]         pre_sum;
    logic [XW-1:0]         pre_sum_x;
    logic [XW-1:0]         tot_x;
    logic [XW-1:0]         pre_x;
    logic                  fit;

    assign cmd = q_head.cmd;
    assign fire = q_head.vld && (!out_vld_reg || result_out.ready);
    assign n_res = 3'(cmd.rep_cnt) + 3'(cmd.tail_vld);
    assign is_rep = (idx_reg < cmd.rep_cnt);
    assign is_last = (3'(idx_reg) + 3'd1 == n_res);
    assign q_pop = fire && is_last;

    assign cur_cp = is_rep ? u8dw_pkg::REPL_CP : cmd.tail_cp;
    assign cur_cnt = is_rep ? 3'd1 : cmd.tail_cnt;
    assign cur_w = is_rep ? u8dw_pkg::REPL_COLS : cmd.tail_w;
    assign cur_rep = is_rep ? 1'b1 : cmd.tail_rep;

    assign tot_sum = SW'(total_reg) + SW'(cur_w);
    assign pre_sum = SW'(prefix_reg) + SW'(cur_w);
    assign pre_sum_x = XW'(pre_sum);
    assign fit = open_reg && (max_width != 16'd0) && (pre_sum_x <= XW'(max_width));

    always_comb
    begin
        total_next = tot_sum[COUNT_BITS] ? '1 : tot_sum[COUNT_BITS-1:0];
        prefix_next = prefix_reg;
        open_next = open_reg && fit;
        if (fit)
        begin
            prefix_next = pre_sum[COUNT_BITS] ? '1 : pre_sum[COUNT_BITS-1:0];
        end
        idx_next = is_last ? 2'd0 : idx_reg + 2'd1;
    end

    assign tot_x = XW'(total_next);
    assign pre_x = XW'(prefix_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
            total_reg <= '0;
            prefix_reg <= '0;
            open_reg <= 1'b1;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                idx_reg <= idx_next;
                out_vld_reg <= 1'b1;
                if (is_last && cmd.last)
                begin
                    // end of text: fresh counters for the next one
                    total_reg <= '0;
                    prefix_reg <= '0;
                    open_reg <= 1'b1;
                end
                else
                begin
                    total_reg <= total_next;
                    prefix_reg <= prefix_next;
                    open_reg <= open_next;
                end
            end
            else if (result_out.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            cp_reg <= cur_cp;
            cnt_reg <= cur_cnt;
            w_reg <= cur_w;
            rep_reg <= cur_rep;
            tot_out_reg <= tot_x[15:0];
            pre_out_reg <= pre_x[15:0];
            fit_reg <= fit;
            run_end_reg <= is_last;
            text_end_reg <= is_last && cmd.last;
        end
    end

    assign result_out.valid = out_vld_reg;
    assign result_out.code_point = cp_reg;
    assign result_out.byte_count = cnt_reg;
    assign result_out.col_width = w_reg;
    assign result_out.replaced = rep_reg;
    assign result_out.total_width = tot_out_reg;
    assign result_out.prefix_width = pre_out_reg;
    assign result_out.fits = fit_reg;
    assign result_out.last_of_run = run_end_reg;
    assign result_out.end_of_text = text_end_reg;

endmodule

/* rtl/utf8_display_width_meter.sv */
// top level of the utf-8 display width meter
// Takes one text byte per cycle while the command queue has room and gives one result
// beat per decoded code point or replacement, carrying its column width, the saturating
// running total and the fitting-prefix width against max_width. Most bytes give at most
// one beat, so the stream runs at one byte per cycle unless the result sink stalls; a
// bad or truncated sequence gives up to four beats for one byte, which the result stage
// sends at one beat per cycle while the sink is ready; the QUEUE_DEPTH-entry command
// queue between decoder and result stage takes further bytes. Each byte's command is
// queued, then registered. Write max_width only while no beats are outstanding.
module utf8_display_width_meter #(
    parameter int COUNT_BITS  = u8dw_pkg::COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = u8dw_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    u8dw_byte_if.sink   text_in,
    u8dw_res_if.source  result_out,
    u8dw_cfg_if.sink    cfg
);

    logic [15:0]        max_width_reg;
    u8dw_pkg::q_push_t  q_push;
    u8dw_pkg::q_head_t  q_head;
    logic               q_full;
    logic               q_pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_width_reg <= u8dw_pkg::MAX_WIDTH_RST;
        end
        else if (cfg.valid)
        begin
            max_width_reg <= cfg.max_width;
        end
    end

    u8dw_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .text_in (text_in),
        .q_full  (q_full),
        .q_push  (q_push)
    );

    u8dw_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_push (q_push),
        .q_full (q_full),
        .q_head (q_head),
        .q_pop  (q_pop)
    );

    u8dw_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .max_width  (max_width_reg),
        .result_out (result_out)
    );

endmodule

/* rtl/u8dw_checker.sv */
// port-level checks of the display width meter and their binding
module u8dw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [20:0] code_point,
    input logic [2:0]  byte_count,
    input logic [1:0]  col_width,
    input logic        replaced,
    input logic        last_of_run,
    input logic        end_of_text
);

    // a stalled beat stays offered
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result beat dropped while stalled");

    // replacement beats are one byte, one column
    a_repl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && replaced |->
            code_point == 21'h00FFFD && byte_count == 3'd1 && col_width == 2'd1)
        else $error("malformed replacement beat");

    a_eot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_text |-> last_of_run)
        else $error("end of text without end of run");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_count != 3'd0 && byte_count <= 3'd4 && col_width != 2'd3)
        else $error("byte count or column width out of range");

endmodule

bind utf8_display_width_meter u8dw_checker u_u8dw_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result_out.valid),
    .out_ready   (result_out.ready),
    .code_point  (result_out.code_point),
    .byte_count  (result_out.byte_count),
    .col_width   (result_out.col_width),
    .replaced    (result_out.replaced),
    .last_of_run (result_out.last_of_run),
    .end_of_text (result_out.end_of_text)
);

/* tb/tb.sv */
// self-checking testbench of the utf-8 display width meter with its own width predictor
`timescale 1ns / 100ps

module tb;

    localparam int CNT_MAX = (1 << u8dw_pkg::COUNT_BITS_DEF) - 1;
    localparam u8dw_pkg::cp_t NARROW_END = 21'h00300;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_BYTES = 25;
    localparam int DIRECTED_N = 22;

    localparam logic [7:0] DIRECTED_BYTES [DIRECTED_N] = '{
        8'h00, 8'h7F, 8'hC0, 8'h80, 8'hE4, 8'hB8, 8'hAD, 8'hCC, 8'h81, 8'hF7, 8'hBF,
        8'hBF, 8'hBF, 8'h80, 8'hFF, 8'hF0, 8'h9F, 8'h98, 8'h41, 8'hE4, 8'hB8, 8'hC3};
    localparam bit DIRECTED_LAST [DIRECTED_N] = '{
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
    } text_item_t;

    typedef struct packed {
        u8dw_pkg::cp_t code_point;
        logic [2:0]    byte_count;
        logic [1:0]    col_width;
        logic          replaced;
        logic [15:0]   total_width;
        logic [15:0]   prefix_width;
        logic          fits;
        logic          last_of_run;
        logic          end_of_text;
    } beat_t;

    logic clk;
    logic rst_n;

    u8dw_byte_if text_if ();
    u8dw_res_if  res_if ();
    u8dw_cfg_if  cfg_if ();

    utf8_display_width_meter i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_in    (text_if),
        .result_out (res_if),
        .cfg        (cfg_if)
    );

    text_item_t text_bytes [$];
    beat_t      expected_beats [$];
    beat_t      run_beats [$];
    text_item_t next_item;

    int src_idle_pct = 30;
    int snk_idle_pct = 70;
    int bytes_added = 0;
    int err_cnt = 0;

    // predictor state
    int            budget = u8dw_pkg::MAX_WIDTH_RST;
    int            need_cnt = 0;
    int            held_cnt = 0;
    u8dw_pkg::cp_t part_cp = '0;
    int            total_cols = 0;
    int            prefix_cols = 0;
    logic          prefix_open = 1'b1;

    function automatic logic [1:0] display_cols(u8dw_pkg::cp_t cp);
        if (cp == '0)
        begin
            return 2'd0;
        end
        if (cp < NARROW_END)
        begin
            return 2'd1;
        end
        for (int i = 0; i < u8dw_pkg::ZERO_N; i++)
        begin
            if (cp >= u8dw_pkg::ZERO_LO[i] && cp <= u8dw_pkg::ZERO_HI[i])
            begin
                return 2'd0;
            end
        end
        for (int i = 0; i < u8dw_pkg::WIDE_N; i++)
        begin
            if (cp >= u8dw_pkg::WIDE_LO[i] && cp <= u8dw_pkg::WIDE_HI[i])
            begin
                return 2'd2;
            end
        end
        return 2'd1;
    endfunction

    function automatic void count_code_point(u8dw_pkg::cp_t cp, logic [2:0] n, logic rep);
        beat_t b;
        logic [1:0] w;
        if (run_beats.size() >= 4)
        begin
            return;
        end
        w = display_cols(cp);
        total_cols = (total_cols + w > CNT_MAX) ? CNT_MAX : total_cols + w;
        b = '0;
        if (prefix_open && budget != 0 && prefix_cols + w <= budget)
        begin
            b.fits = 1'b1;
            prefix_cols = (prefix_cols + w > CNT_MAX) ? CNT_MAX : prefix_cols + w;
        end
        else
        begin
            prefix_open = 1'b0;
        end
        b.code_point   = cp;
        b.byte_count   = n;
        b.col_width    = w;
        b.replaced     = rep;
        b.total_width  = total_cols[15:0];
        b.prefix_width = prefix_cols[15:0];
        run_beats.push_back(b);
    endfunction

    function automatic void replace_held();
        repeat (held_cnt + 1)
        begin
            count_code_point(u8dw_pkg::REPL_CP, 3'd1, 1'b1);
        end
        need_cnt = 0;
        held_cnt = 0;
        part_cp = '0;
    endfunction

    function automatic void decode_fresh(logic [7:0] b, logic last);
        int need;
        u8dw_pkg::cp_t init;
        need = 0;
        init = '0;
        if (b[7] == 1'b0)
        begin
            count_code_point({13'd0, b}, 3'd1, 1'b0);
            return;
        end
        if (b[7:5] == 3'b110)
        begin
            need = 1;
            init = {16'd0, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            need = 2;
            init = {17'd0, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            need = 3;
            init = {18'd0, b[2:0]};
        end
        if (need == 0 || last)
        begin
            count_code_point(u8dw_pkg::REPL_CP, 3'd1, 1'b1);
            return;
        end
        need_cnt = need;
        held_cnt = 0;
        part_cp = init;
    endfunction

    function automatic void meter_byte(logic [7:0] b, logic last);
        if (need_cnt != 0)
        begin
            if (b[7:6] == 2'b10)
            begin
                part_cp = {part_cp[14:0], b[5:0]};
                held_cnt++;
                need_cnt--;
                if (need_cnt == 0)
                begin
                    count_code_point(part_cp, 3'(held_cnt + 1), 1'b0);
                    held_cnt = 0;
                    part_cp = '0;
                end
                else if (last)
                begin
                    replace_held();
                end
            end
            else
            begin
                replace_held();
                decode_fresh(b, last);
            end
        end
        else
        begin
            decode_fresh(b, last);
        end
        if (run_beats.size() != 0)
        begin
            run_beats[run_beats.size() - 1].last_of_run = 1'b1;
            run_beats[run_beats.size() - 1].end_of_text = last;
        end
        foreach (run_beats[i])
        begin
            expected_beats.push_back(run_beats[i]);
        end
        run_beats.delete();
        if (last)
        begin
            need_cnt = 0;
            held_cnt = 0;
            part_cp = '0;
            total_cols = 0;
            prefix_cols = 0;
            prefix_open = 1'b1;
        end
    endfunction

    function automatic string beat_str(beat_t b);
        return $sformatf("cp=%h n=%0d w=%0d rep=%b tot=%0d pre=%0d fit=%b run=%b eot=%b",
            b.code_point, b.byte_count, b.col_width, b.replaced, b.total_width,
            b.prefix_width, b.fits, b.last_of_run, b.end_of_text);
    endfunction

    function automatic void check_beat();
        beat_t got;
        beat_t want;
        got.code_point   = res_if.code_point;
        got.byte_count   = res_if.byte_count;
        got.col_width    = res_if.col_width;
        got.replaced     = res_if.replaced;
        got.total_width  = res_if.total_width;
        got.prefix_width = res_if.prefix_width;
        got.fits         = res_if.fits;
        got.last_of_run  = res_if.last_of_run;
        got.end_of_text  = res_if.end_of_text;
        if (expected_beats.size() == 0)
        begin
            err_cnt++;
            $display("%0t: expected none, actual %s", $time, beat_str(got));
            return;
        end
        want = expected_beats.pop_front();
        if (got !== want)
        begin
            err_cnt++;
            $display("%0t: expected %s, actual %s", $time, beat_str(want), beat_str(got));
        end
    endfunction

    function automatic void add_byte(logic [7:0] b, logic last);
        text_item_t it;
        it.text_byte = b;
        it.last_byte = last;
        text_bytes.push_back(it);
        bytes_added++;
    endfunction

    function automatic void mark_text_end();
        text_bytes[text_bytes.size() - 1].last_byte = 1'b1;
    endfunction

    // len 0 picks the shortest form, keep below len leaves the sequence open
    function automatic void add_code_point(u8dw_pkg::cp_t cp, int len, int keep);
        logic [7:0] enc [4];
        if (len == 0)
        begin
            len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
        end
        if (keep == 0)
        begin
            keep = len;
        end
        case (len)
            1:
            begin
                enc[0] = {1'b0, cp[6:0]};
            end
            2:
            begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3:
            begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < keep; i++)
        begin
            add_byte(enc[i], 1'b0);
        end
    endfunction

    // near or inside a zero or double width range
    function automatic u8dw_pkg::cp_t table_code_point();
        int idx;
        u8dw_pkg::cp_t lo;
        u8dw_pkg::cp_t hi;
        if ($urandom_range(1) == 0)
        begin
            idx = $urandom_range(u8dw_pkg::ZERO_N - 1);
            lo = u8dw_pkg::ZERO_LO[idx];
            hi = u8dw_pkg::ZERO_HI[idx];
        end
        else
        begin
            idx = $urandom_range(u8dw_pkg::WIDE_N - 1);
            lo = u8dw_pkg::WIDE_LO[idx];
            hi = u8dw_pkg::WIDE_HI[idx];
        end
        case ($urandom_range(5))
            0: return lo - 21'd1;
            1: return lo;
            2: return hi;
            3: return hi + 21'd1;
            default: return u8dw_pkg::cp_t'($urandom_range(hi, lo));
        endcase
    endfunction

    function automatic void add_random_text(int nchars);
        int sel;
        int len;
        for (int k = 0; k < nchars; k++)
        begin
            sel = $urandom_range(99);
            if (sel < 25)
            begin
                add_code_point(u8dw_pkg::cp_t'($urandom_range(8'h7F)), 1, 0);
            end
            else if (sel < 40)
            begin
                add_code_point(u8dw_pkg::cp_t'($urandom_range(21'h7FF)), 2, 0);
            end
            else if (sel < 55)
            begin
                add_code_point(u8dw_pkg::cp_t'($urandom_range(21'hFFFF)), 3, 0);
            end
            else if (sel < 65)
            begin
                add_code_point(u8dw_pkg::cp_t'($urandom_range(21'h1FFFFF)), 4, 0);
            end
            else if (sel < 80)
            begin
                add_code_point(table_code_point(), 0, 0);
            end
            else if (sel < 90)
            begin
                len = $urandom_range(4, 2);
                add_code_point(u8dw_pkg::cp_t'($urandom_range(21'h1FFFFF)), len,
                    $urandom_range(len - 1, 1));
            end
            else
            begin
                add_byte(8'($urandom_range(255)), 1'b0);
            end
        end
        mark_text_end();
    endfunction

    function automatic void add_random_texts(int n_bytes);
        int goal;
        goal = bytes_added + n_bytes;
        while (bytes_added < goal)
        begin
            add_random_text($urandom_range(8, 1));
        end
    endfunction

    task automatic wait_idle();
        do
        begin
            @(posedge clk);
        end
        while (text_bytes.size() != 0 || text_if.valid || expected_beats.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_budget(logic [15:0] w);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.max_width <= w;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        budget = w;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        text_if.valid = 1'b0;
        text_if.text_byte = '0;
        text_if.last_byte = 1'b0;
        res_if.ready = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.max_width = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
    end

    // byte driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            text_if.valid <= 1'b0;
            text_if.text_byte <= '0;
            text_if.last_byte <= 1'b0;
        end
        else
        begin
            if (text_if.valid && text_if.ready)
            begin
                meter_byte(text_if.text_byte, text_if.last_byte);
            end
            if (!text_if.valid || text_if.ready)
            begin
                if (text_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    next_item = text_bytes.pop_front();
                    text_if.valid <= 1'b1;
                    text_if.text_byte <= next_item.text_byte;
                    text_if.last_byte <= next_item.last_byte;
                end
                else
                begin
                    text_if.valid <= 1'b0;
                end
            end
        end
    end

    // result beat monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                check_beat();
            end
            res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial
    begin
        wait (rst_n);
        @(posedge clk);

        for (int i = 0; i < DIRECTED_N; i++)
        begin
            add_byte(DIRECTED_BYTES[i], DIRECTED_LAST[i]);
        end
        wait_idle();

        write_budget(16'd0);
        add_random_texts(RANDOM_BYTES);
        wait_idle();

        src_idle_pct = 70;
        snk_idle_pct = 30;
        write_budget(16'd7);
        add_random_texts(RANDOM_BYTES);
        wait_idle();

        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_budget(16'hFFFF);
        add_random_texts(RANDOM_BYTES);
        wait_idle();

        write_budget(16'd1);
        add_random_texts(RANDOM_BYTES);
        wait_idle();

        if (err_cnt == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

/* files.f */
rtl/u8dw_pkg.sv
rtl/u8dw_ifs.sv
rtl/u8dw_front.sv
rtl/u8dw_queue.sv
rtl/u8dw_back.sv
rtl/utf8_display_width_meter.sv
rtl/u8dw_checker.sv
tb/tb.sv
